>>> design/assert_macros.svh
// Assertion macros used by the refresh core.
// All of them sample on the rising edge of clock and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`define ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> design/dpdr_pkg.sv
package dpdr_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_PAGES = 8;
   localparam int CHUNK_BYTES = 64;
   localparam int WORD_BYTES = 8;

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int LANE_W = $clog2(WORD_BYTES);
   localparam int WSEL_W = COL_W - LANE_W;
   localparam int CHUNK_W = $clog2(CHUNK_BYTES);
   localparam int WORDS_PER_PAGE = MAX_COLUMNS / WORD_BYTES;
   localparam int RAM_DEPTH = MAX_PAGES * WORDS_PER_PAGE;
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);
   localparam int WORD_W = 8 * WORD_BYTES;

   localparam int COLS_W = 8;
   localparam int PAGES_W = 4;
   localparam int PAYLOAD_W = 64;
   localparam int COUNT_W = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(MAX_COLUMNS);
   localparam logic [PAGES_W-1:0] PAGES_MAX = PAGES_W'(MAX_PAGES);
   localparam logic [COLS_W-1:0] COLS_RESET = 8'd128;
   localparam logic [PAGES_W-1:0] PAGES_RESET = 4'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT = 2'd1;

   localparam logic [7:0] CMD_SET_PAGE = 8'hB0;
   localparam logic [7:0] CMD_LOW_COL = 8'h00;
   localparam logic [7:0] CMD_HIGH_COL = 8'h10;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       frame_start;
   } req_beat_type;

   typedef struct packed {
      logic                 is_data;
      logic [PAYLOAD_W-1:0] payload;
      logic [COUNT_W-1:0]   byte_count;
      logic                 write_end;
      logic                 last;
   } rsp_beat_type;

endpackage

>>> design/dirty_page_display_refresh_core.sv
// Channel | Direction | Handshake           | Beat
// req     | in        | req_valid/req_stall | req_beat: byte_value, frame_start
// rsp     | out       | rsp_valid/rsp_stall | rsp_beat: is_data, payload, byte_count, ...
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// Every input byte is accepted with a cache read, then goes through a read-modify-write.
// A page that is sent adds three command beats, then its data words, each read through
// the single read port of the shadow cache RAM (8 bytes per word) before it is sent.
// Reset is synchronous; the cache contents are not cleared.
// A stalled result holds in the output register while the next byte is accepted.
module dirty_page_display_refresh_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dpdr_pkg::req_beat_type              req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dpdr_pkg::rsp_beat_type              rsp_beat,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dpdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata
);

   import dpdr_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RMW  = 5'b00010,
      S_CMD  = 5'b00100,
      S_READ = 5'b01000,
      S_DATA = 5'b10000
   } state_type;

   localparam logic [1:0] STEP_PAGE = 2'd0;
   localparam logic [1:0] STEP_LOW = 2'd1;
   localparam logic [1:0] STEP_HIGH = 2'd2;

   state_type state_ff, state_in;

   logic [COLS_W-1:0]  cfg_columns_ff;
   logic [PAGES_W-1:0] cfg_pages_ff;
   logic [COLS_W-1:0]  cols_eff;
   logic [PAGES_W-1:0] pages_eff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              changed_ff, changed_in;
   logic              first_ff, first_in;
   logic [7:0]        byte_ff;
   logic [PAGE_W-1:0] emit_page_ff, emit_page_in;
   logic [1:0]        step_ff, step_in;
   logic [WSEL_W-1:0] word_ff, word_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  load;
   logic [COL_W-1:0]      acc_col;
   logic [PAGE_W-1:0]     acc_page;

   logic                  ram_rd_en;
   logic [RAM_ADDR_W-1:0] ram_rd_addr;
   logic                  ram_wr_en;
   logic [RAM_ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic [WORD_W-1:0]     ram_rd_data;

   logic [7:0]         old_byte;
   logic               page_end;
   logic [COLS_W-1:0]  data_base;
   logic [COLS_W-1:0]  data_rem;
   logic [COLS_W-1:0]  data_next;
   logic [COUNT_W-1:0] data_count;
   logic               data_final;
   logic [WORD_W-1:0]  data_word;
   logic [7:0]         cmd_byte;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_beat_ff;

   always_comb begin
      if (cfg_columns_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (cfg_columns_ff > COLS_MAX) begin
         cols_eff = COLS_MAX;
      end else begin
         cols_eff = cfg_columns_ff;
      end
      if (cfg_pages_ff == '0) begin
         pages_eff = PAGES_W'(1);
      end else if (cfg_pages_ff > PAGES_MAX) begin
         pages_eff = PAGES_MAX;
      end else begin
         pages_eff = cfg_pages_ff;
      end
   end

   assign acc_col = req_beat.frame_start ? '0 : col_ff;
   assign acc_page = req_beat.frame_start ? '0 : page_ff;

   dpdr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(RAM_DEPTH)
   ) u_cache (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      ram_rd_en = 1'b0;
      ram_rd_addr = {acc_page, acc_col[COL_W-1:LANE_W]};
      if (req_fire) begin
         ram_rd_en = 1'b1;
      end else if (state_ff == S_READ) begin
         ram_rd_en = 1'b1;
         ram_rd_addr = {emit_page_ff, word_ff};
      end
   end

   assign ram_wr_en = (state_ff == S_RMW);
   assign ram_wr_addr = {page_ff, col_ff[COL_W-1:LANE_W]};
   assign old_byte = ram_rd_data[8*col_ff[LANE_W-1:0] +: 8];

   always_comb begin
      ram_wr_data = ram_rd_data;
      ram_wr_data[8*col_ff[LANE_W-1:0] +: 8] = byte_ff;
   end

   assign page_end = ({1'b0, col_ff} + COLS_W'(1)) >= cols_eff;

   assign data_base = COLS_W'({word_ff, {LANE_W{1'b0}}});
   assign data_rem = cols_eff - data_base;
   assign data_next = data_base + COLS_W'(WORD_BYTES);
   assign data_final = data_rem <= COLS_W'(WORD_BYTES);
   assign data_count = data_final ? COUNT_W'(data_rem) : COUNT_W'(WORD_BYTES);

   always_comb begin
      data_word = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (COUNT_W'(i) < data_count) begin
            data_word[8*i +: 8] = ram_rd_data[8*i +: 8];
         end
      end
   end

   always_comb begin
      case (step_ff)
         STEP_PAGE: cmd_byte = CMD_SET_PAGE + 8'(emit_page_ff);
         STEP_LOW:  cmd_byte = CMD_LOW_COL;
         STEP_HIGH: cmd_byte = CMD_HIGH_COL;
         default:   cmd_byte = CMD_HIGH_COL;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      page_in = page_ff;
      changed_in = changed_ff;
      first_in = first_ff;
      emit_page_in = emit_page_ff;
      step_in = step_ff;
      word_in = word_ff;
      load = 1'b0;
      rsp_beat_in = rsp_beat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               col_in = acc_col;
               page_in = acc_page;
               if (req_beat.frame_start) begin
                  changed_in = 1'b0;
               end
               state_in = S_RMW;
            end
         end
         S_RMW: begin
            if (page_end) begin
               emit_page_in = page_ff;
               step_in = STEP_PAGE;
               word_in = '0;
               changed_in = 1'b0;
               col_in = '0;
               if (({1'b0, page_ff} + PAGES_W'(1)) >= pages_eff) begin
                  page_in = '0;
                  first_in = 1'b0;
               end else begin
                  page_in = page_ff + PAGE_W'(1);
               end
               state_in = (changed_ff || (old_byte != byte_ff) || first_ff) ? S_CMD : S_IDLE;
            end else begin
               changed_in = changed_ff || (old_byte != byte_ff);
               col_in = col_ff + COL_W'(1);
               state_in = S_IDLE;
            end
         end
         S_CMD: begin
            if (out_free) begin
               load = 1'b1;
               rsp_beat_in.is_data = 1'b0;
               rsp_beat_in.payload = PAYLOAD_W'(cmd_byte);
               rsp_beat_in.byte_count = COUNT_W'(1);
               rsp_beat_in.write_end = 1'b1;
               rsp_beat_in.last = 1'b0;
               if (step_ff == STEP_HIGH) begin
                  state_in = S_READ;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         S_READ: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               load = 1'b1;
               rsp_beat_in.is_data = 1'b1;
               rsp_beat_in.payload = PAYLOAD_W'(data_word);
               rsp_beat_in.byte_count = data_count;
               rsp_beat_in.write_end = data_final || (data_next[CHUNK_W-1:0] == '0);
               rsp_beat_in.last = data_final;
               if (data_final) begin
                  state_in = S_IDLE;
               end else begin
                  word_in = word_ff + WSEL_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff <= '0;
         page_ff <= '0;
         changed_ff <= 1'b0;
         first_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cfg_columns_ff <= COLS_RESET;
         cfg_pages_ff <= PAGES_RESET;
         step_ff <= STEP_PAGE;
         word_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         page_ff <= page_in;
         changed_ff <= changed_in;
         first_ff <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in;
         word_ff <= word_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COLUMNS) begin
               cfg_columns_ff <= csr_wdata;
            end else if (csr_index == CSR_PAGE_COUNT) begin
               cfg_pages_ff <= csr_wdata[PAGES_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_beat.byte_value;
      end
      emit_page_ff <= emit_page_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   `ASSERT_NEXT(a_write_follows_read, req_fire, ram_wr_en, "cache write missing after byte read")
   `ASSERT_IMPLIES(a_load_when_free, load, out_free, "result loaded over a waiting result")
   `ASSERT_IMPLIES(a_cmd_ends_write, rsp_valid_ff && !rsp_beat_ff.is_data,
      rsp_beat_ff.write_end && rsp_beat_ff.byte_count == COUNT_W'(1), "malformed command beat")
   `ASSERT_IMPLIES(a_count_range, rsp_valid_ff,
      rsp_beat_ff.byte_count != '0 && rsp_beat_ff.byte_count <= COUNT_W'(WORD_BYTES),
      "byte count out of range")

endmodule

>>> design/dpdr_ram.sv
module dpdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> bench/dpdr_refresh_checker.sv
module dpdr_refresh_checker
   import dpdr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_beat_type           req_beat,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_beat_type           rsp_beat,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     error_count,
   output int                     outstanding
);

   logic [COLS_W-1:0]  columns_reg;
   logic [PAGES_W-1:0] page_count_reg;
   logic [7:0]         shadow [0:MAX_COLUMNS*MAX_PAGES-1];
   int                 col_pos;
   int                 page_pos;
   logic               page_dirty;
   logic               first_frame;
   rsp_beat_type       display_writes_q [$];
   int                 mismatches = 0;

   function automatic rsp_beat_type bus_write(input logic is_data, input logic [63:0] payload,
                                              input int count, input logic wend,
                                              input logic final_one);
      rsp_beat_type w;
      w.is_data    = is_data;
      w.payload    = payload;
      w.byte_count = COUNT_W'(count);
      w.write_end  = wend;
      w.last       = final_one;
      return w;
   endfunction

   task automatic queue_page(input int page, input int cols);
      int          start;
      int          len;
      int          off;
      int          m;
      logic [7:0]  cmd;
      logic [63:0] word;
      cmd = CMD_SET_PAGE + 8'(page);
      display_writes_q.push_back(bus_write(1'b0, 64'(cmd), 1, 1'b1, 1'b0));
      display_writes_q.push_back(bus_write(1'b0, 64'(CMD_LOW_COL), 1, 1'b1, 1'b0));
      display_writes_q.push_back(bus_write(1'b0, 64'(CMD_HIGH_COL), 1, 1'b1, 1'b0));
      for (start = 0; start < cols; start += CHUNK_BYTES) begin
         len = (cols - start > CHUNK_BYTES) ? CHUNK_BYTES : cols - start;
         for (off = 0; off < len; off += WORD_BYTES) begin
            m = (len - off > WORD_BYTES) ? WORD_BYTES : len - off;
            word = '0;
            for (int i = 0; i < m; i++) begin
               word[8*i +: 8] = shadow[page*MAX_COLUMNS + start + off + i];
            end
            display_writes_q.push_back(bus_write(1'b1, word, m, off + m >= len,
                                                 start + off + m >= cols));
         end
      end
   endtask

   task automatic absorb_byte(input req_beat_type beat);
      int cols;
      int pages;
      int addr;
      cols = (columns_reg == 0) ? 1 :
             (int'(columns_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
      pages = (page_count_reg == 0) ? 1 :
              (int'(page_count_reg) > MAX_PAGES) ? MAX_PAGES : int'(page_count_reg);
      if (beat.frame_start) begin
         col_pos    = 0;
         page_pos   = 0;
         page_dirty = 1'b0;
      end
      addr = page_pos * MAX_COLUMNS + col_pos;
      if (shadow[addr] != beat.byte_value) page_dirty = 1'b1;
      shadow[addr] = beat.byte_value;
      if (col_pos + 1 >= cols) begin
         if (page_dirty || first_frame) queue_page(page_pos, cols);
         page_dirty = 1'b0;
         col_pos    = 0;
         if (page_pos + 1 >= pages) begin
            page_pos    = 0;
            first_frame = 1'b0;
         end else begin
            page_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   task automatic check_write(input rsp_beat_type got);
      rsp_beat_type want;
      if (display_writes_q.size() == 0) begin
         mismatches++;
         $error("rsp beat with nothing expected: payload %h", got.payload);
      end else begin
         want = display_writes_q.pop_front();
         if (got.is_data !== want.is_data) begin
            mismatches++;
            $error("is_data: expected %0d, actual %0d", want.is_data, got.is_data);
         end
         if (got.payload !== want.payload) begin
            mismatches++;
            $error("payload: expected %h, actual %h", want.payload, got.payload);
         end
         if (got.byte_count !== want.byte_count) begin
            mismatches++;
            $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
         end
         if (got.write_end !== want.write_end) begin
            mismatches++;
            $error("write_end: expected %0d, actual %0d", want.write_end, got.write_end);
         end
         if (got.last !== want.last) begin
            mismatches++;
            $error("last: expected %0d, actual %0d", want.last, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         columns_reg    = COLS_RESET;
         page_count_reg = PAGES_RESET;
         col_pos        = 0;
         page_pos       = 0;
         page_dirty     = 1'b0;
         first_frame    = 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) check_write(rsp_beat);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COLUMNS) columns_reg = csr_wdata;
            else if (csr_index == CSR_PAGE_COUNT) page_count_reg = csr_wdata[PAGES_W-1:0];
         end
         if (req_valid && !req_stall) absorb_byte(req_beat);
      end
      outstanding <= display_writes_q.size();
      error_count <= mismatches;
   end

endmodule

>>> bench/tb_dirty_page_display_refresh_core.sv
module tb_dirty_page_display_refresh_core;
   import dpdr_pkg::*;

   localparam int TOTAL_ITEMS  = 380;
   localparam int DRAIN_CYCLES = 48;
   localparam int STUCK_LIMIT  = 1000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_beat_type           req_beat;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_beat_type           rsp_beat;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;
   int                     error_count;
   int                     outstanding;

   logic [7:0] frame_image [0:MAX_COLUMNS*MAX_PAGES-1];
   logic       aligned;
   int         items_sent   = 0;
   int         req_calm     = 0;
   int         stall_left   = 0;
   int         stuck_cycles = 0;

   dirty_page_display_refresh_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dpdr_refresh_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(input int long_lo, input int long_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(long_lo, long_hi);
   endfunction

   function automatic int eff_cols(input logic [7:0] raw);
      if (raw == 0) return 1;
      if (int'(raw) > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(raw);
   endfunction

   function automatic int eff_pages(input logic [3:0] raw);
      if (raw == 0) return 1;
      if (int'(raw) > MAX_PAGES) return MAX_PAGES;
      return int'(raw);
   endfunction

   always @(posedge clock) begin : stall_gen
      int g;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) :
                                                     $urandom_range(0, 6);
      end else begin
         g = draw_gap(20, 60);
         if (g > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= g - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("tb_dirty_page_display_refresh_core: done, errors");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic start);
      req_beat_type beat;
      int           gap;
      beat.byte_value  = value;
      beat.frame_start = start;
      if (req_calm > 0) begin
         req_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) req_calm = $urandom_range(16, 64);
         gap = draw_gap(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= beat;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic put(input int page, input int col, input logic [7:0] value,
                      input logic start);
      frame_image[page*MAX_COLUMNS + col] = value;
      send_byte(value, start);
   endtask

   // Each page is either resent as is, touched in a few bytes, or redrawn.
   task automatic send_frame(input int cols, input int pages, input logic start,
                             input int cut);
      int         k;
      int         mode;
      logic [7:0] value;
      k = 0;
      for (int p = 0; p < pages; p++) begin
         mode = $urandom_range(0, 99);
         for (int c = 0; c < cols; c++) begin
            if (k == cut) return;
            value = frame_image[p*MAX_COLUMNS + c];
            if (mode >= 80 || (mode >= 45 && $urandom_range(0, 7) == 0)) value = 8'($urandom);
            put(p, c, value, start && k == 0);
            k++;
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] cols_raw, input logic [7:0] pages_raw);
      csr_valid <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols_raw;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_PAGE_COUNT;
      csr_wdata <= pages_raw;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] cols_raw;
      logic [7:0] pages_raw;
      int         ncols;
      int         npages;
      int         frames;
      int         cut;
      int         r;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_beat  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The first frame refreshes every page. It fills all of page 0 and the first
      // eight columns of every page, which is the area used for the rest of the run.
      put(0, 0, 8'h00, 1'b1);
      put(0, 1, 8'hFF, 1'b0);
      for (int c = 2; c < MAX_COLUMNS; c++) put(0, c, 8'($urandom), 1'b0);
      settle();
      write_regs(8'd8, 8'd8);
      send_frame(8, 8, 1'b1, -1);

      // Out-of-range settings clamp to one column and eight pages. An identical frame
      // sends nothing, then one changed page is sent alone.
      settle();
      write_regs(8'd0, 8'd15);
      for (int p = 0; p < MAX_PAGES; p++) put(p, 0, frame_image[p*MAX_COLUMNS], p == 0);
      for (int p = 0; p < MAX_PAGES; p++) begin
         put(p, 0, (p == 5) ? ~frame_image[p*MAX_COLUMNS] : frame_image[p*MAX_COLUMNS],
             1'b0);
      end

      // A frame start in the middle of a page drops the pending change.
      settle();
      write_regs(8'd2, 8'd0);
      put(0, 0, ~frame_image[0], 1'b1);
      put(0, 0, frame_image[0], 1'b1);
      put(0, 1, frame_image[1], 1'b0);

      // Shrinking the width past the current column ends the page on the next byte.
      settle();
      write_regs(8'd8, 8'd1);
      put(0, 0, frame_image[0], 1'b1);
      put(0, 1, frame_image[1], 1'b0);
      put(0, 2, ~frame_image[2], 1'b0);
      put(0, 3, frame_image[3], 1'b0);
      put(0, 4, frame_image[4], 1'b0);
      settle();
      write_regs(8'd3, 8'd1);
      put(0, 5, frame_image[5], 1'b0);

      // Shrinking the page count past the current page ends the frame on the next byte.
      settle();
      write_regs(8'd1, 8'd8);
      for (int p = 0; p < 5; p++) put(p, 0, frame_image[p*MAX_COLUMNS], p == 0);
      settle();
      write_regs(8'd1, 8'd2);
      put(5, 0, ~frame_image[5*MAX_COLUMNS], 1'b0);
      put(0, 0, frame_image[0], 1'b0);
      put(1, 0, frame_image[MAX_COLUMNS], 1'b0);
      aligned = 1'b1;

      // Wide settings stay on page 0; tall settings stay within eight columns.
      while (items_sent < TOTAL_ITEMS) begin
         settle();
         if ($urandom_range(0, 99) < 40) begin
            r = $urandom_range(0, 9);
            cols_raw = (r == 0) ? 8'd255 :
                       (r == 1) ? 8'd128 :
                       (r == 2) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(9, 72));
            pages_raw = {4'($urandom), 4'($urandom_range(0, 1))};
         end else begin
            cols_raw  = 8'($urandom_range(0, 8));
            pages_raw = 8'($urandom);
         end
         write_regs(cols_raw, pages_raw);
         ncols  = eff_cols(cols_raw);
         npages = eff_pages(pages_raw[3:0]);
         frames = (ncols >= 100) ? 1 : $urandom_range(1, 3);
         repeat (frames) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ncols*npages - 1) : -1;
            send_frame(ncols, npages, !aligned || ($urandom_range(0, 1) == 1), cut);
            aligned = (cut < 0);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("tb_dirty_page_display_refresh_core: done, clean");
      end else begin
         $display("tb_dirty_page_display_refresh_core: done, errors");
      end
      $finish;
   end

endmodule
